// ===== rtl/jrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_pkg: shared definitions for the justified row layout block
// Widths, register indexes, reset values and the command and status types
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package jrl_pkg;

  // Row buffer depth and the widths that follow from it.
  localparam int MAX_ROW_ITEMS = 16;
  localparam int FILL_W = $clog2(MAX_ROW_ITEMS + 1);
  localparam int K_W    = $clog2(MAX_ROW_ITEMS);
  localparam int SUM_W  = $clog2(MAX_ROW_ITEMS * 32768 + 1);
  localparam int MA_W   = SUM_W + 12;
  localparam int MB_W   = 16;
  localparam int MR_W   = MA_W + MB_W;
  localparam int NAT_W  = MA_W + 1;

  // Fixed field widths.
  localparam int ASPECT_W = 16;
  localparam int IDX_W    = 20;
  localparam int Q24_W    = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_N      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N);

  // Aspect limits in Q4.12.
  localparam logic [ASPECT_W-1:0] ASPECT_ONE = 16'd4096;
  localparam logic [ASPECT_W-1:0] ASPECT_MIN = 16'd512;
  localparam logic [ASPECT_W-1:0] ASPECT_MAX = 16'd32768;

  // Register limits and reset values.
  localparam logic [15:0] VIEWPORT_MIN   = 16'd64;
  localparam logic [11:0] ROW_H_MIN      = 12'd16;
  localparam logic [15:0] VIEWPORT_RESET = 16'd1024;
  localparam logic [11:0] ROW_H_RESET    = 12'd200;
  localparam logic [7:0]  GAP_RESET      = 8'd8;
  localparam logic [15:0] STRETCH_RESET  = 16'd6144;
  localparam logic [15:0] AVAIL_MIN      = 16'd32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRETCH = 8'd3;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_NEXT,
    OP_MUL_SUM,
    OP_PUSH,
    OP_F_MUL1,
    OP_F_MUL2,
    OP_F_KEEP,
    OP_DIV_STEP,
    OP_F_H,
    OP_T_MUL,
    OP_T_EMIT,
    OP_F_END,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   final_row;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic nat_ge;
    logic tie_ok;
    logic keep;
    logic div_last;
    logic k_last;
    logic pend_valid;
    logic out_free;
    logic last_item;
  } dp_status_t;

  typedef struct packed {
    logic [IDX_W-1:0] image_index;
    logic [Q24_W-1:0] tile_x;
    logic [Q24_W-1:0] tile_y;
    logic [Q24_W-1:0] tile_width;
    logic [Q24_W-1:0] tile_height;
    logic             last_of_run;
    logic             layout_done;
    logic [Q24_W-1:0] gallery_height;
  } tile_t;

endpackage

// ===== rtl/jrl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_in_if: image input channel
// Carries one sanitisable aspect ratio and the end-of-gallery mark per item.
// ----------------------------------------------------------------------------
interface jrl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] aspect;
  logic        last_image;

  modport source (output valid, output aspect, output last_image, input ready);
  modport sink   (input valid, input aspect, input last_image, output ready);
endinterface

// ===== rtl/jrl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_out_if: tile output channel
// Carries one placed tile per item.
// ----------------------------------------------------------------------------
interface jrl_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] image_index;
  logic [23:0] tile_x;
  logic [23:0] tile_y;
  logic [23:0] tile_width;
  logic [23:0] tile_height;
  logic        last_of_run;
  logic        layout_done;
  logic [23:0] gallery_height;

  modport source (output valid, output image_index, output tile_x, output tile_y,
                  output tile_width, output tile_height, output last_of_run,
                  output layout_done, output gallery_height, input ready);
  modport sink   (input valid, input image_index, input tile_x, input tile_y,
                  input tile_width, input tile_height, input last_of_run,
                  input layout_done, input gallery_height, output ready);
endinterface

// ===== rtl/jrl_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_cfg_if: configuration write channel
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface jrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/jrl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_ctrl: layout sequencer
// Walks each item through the full-row check, the fit decision, the push
// and up to two row flushes, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module jrl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output jrl_pkg::dp_cmd_t     cmd,
  input  jrl_pkg::dp_status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE, S_FULLCHK, S_DMUL_N, S_DMUL_S, S_DCMP, S_PUSH, S_F_MUL1, S_F_MUL2,
    S_F_KEEP, S_DIV, S_F_H, S_T_MUL, S_T_EMIT, S_F_END, S_LASTCHK, S_FIN
  } state_t;

  // What the current flush or push leads on to.
  typedef enum logic [2:0] {
    PH_FULL, PH_PTF, PH_FTP, PH_PONLY, PH_FINAL
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd.op        = jrl_pkg::OP_NOP;
    cmd.final_row = (phase_r == PH_FINAL);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = jrl_pkg::OP_LOAD;
          state_nxt = S_FULLCHK;
        end
      end
      S_FULLCHK: begin
        if (status.fill_full) begin
          phase_nxt = PH_FULL;
          state_nxt = S_F_MUL1;
        end else begin
          state_nxt = S_DMUL_N;
        end
      end
      S_DMUL_N: begin
        cmd.op    = jrl_pkg::OP_MUL_NEXT;
        state_nxt = S_DMUL_S;
      end
      S_DMUL_S: begin
        cmd.op    = jrl_pkg::OP_MUL_SUM;
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if (status.nat_ge && !status.fill_zero && !status.tie_ok) begin
          phase_nxt = PH_FTP;
          state_nxt = S_F_MUL1;
        end else if (status.nat_ge) begin
          phase_nxt = PH_PTF;
          state_nxt = S_PUSH;
        end else begin
          phase_nxt = PH_PONLY;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.op    = jrl_pkg::OP_PUSH;
        state_nxt = (phase_r == PH_PTF) ? S_F_MUL1 : S_LASTCHK;
      end
      S_F_MUL1: begin
        cmd.op    = jrl_pkg::OP_F_MUL1;
        state_nxt = S_F_MUL2;
      end
      S_F_MUL2: begin
        cmd.op    = jrl_pkg::OP_F_MUL2;
        state_nxt = S_F_KEEP;
      end
      S_F_KEEP: begin
        cmd.op    = jrl_pkg::OP_F_KEEP;
        state_nxt = status.keep ? S_F_H : S_DIV;
      end
      S_DIV: begin
        cmd.op = jrl_pkg::OP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = S_F_H;
        end
      end
      S_F_H: begin
        cmd.op    = jrl_pkg::OP_F_H;
        state_nxt = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.op    = jrl_pkg::OP_T_MUL;
        state_nxt = S_T_EMIT;
      end
      S_T_EMIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.op    = jrl_pkg::OP_T_EMIT;
          state_nxt = status.k_last ? S_F_END : S_T_MUL;
        end
      end
      S_F_END: begin
        cmd.op = jrl_pkg::OP_F_END;
        unique case (phase_r)
          PH_FULL:  state_nxt = S_DMUL_N;
          PH_FTP:   state_nxt = S_PUSH;
          PH_FINAL: state_nxt = S_FIN;
          default:  state_nxt = S_LASTCHK;
        endcase
      end
      S_LASTCHK: begin
        if (status.last_item) begin
          phase_nxt = PH_FINAL;
          state_nxt = status.fill_zero ? S_FIN : S_F_MUL1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.op    = jrl_pkg::OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_PONLY;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/jrl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_dp: layout datapath
// Holds the registers, the open row, the shared multiplier, the radix-2
// divider for the row scale and the pending and output tile registers.
// ----------------------------------------------------------------------------
module jrl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jrl_pkg::dp_cmd_t                  cmd,
  output jrl_pkg::dp_status_t               status,
  input  logic                              cfg_we,
  input  logic [jrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jrl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [jrl_pkg::ASPECT_W-1:0]      in_aspect,
  input  logic                              in_last,
  input  logic                              out_ready,
  output logic                              out_valid,
  output jrl_pkg::tile_t                    out_tile
);

  localparam int SUM_W = jrl_pkg::SUM_W;
  localparam int MA_W  = jrl_pkg::MA_W;
  localparam int MB_W  = jrl_pkg::MB_W;
  localparam int MR_W  = jrl_pkg::MR_W;
  localparam int NAT_W = jrl_pkg::NAT_W;
  localparam int FILL_W = jrl_pkg::FILL_W;
  localparam int K_W   = jrl_pkg::K_W;
  localparam int Q24_W = jrl_pkg::Q24_W;
  localparam int IDX_W = jrl_pkg::IDX_W;
  localparam int GT_W  = 8 + FILL_W + 1;

  // Registers of the configuration port.
  logic [15:0] vw_r;
  logic [11:0] rh_r;
  logic [7:0]  gap_r;
  logic [15:0] ms_r;

  // Item and row state.
  logic [15:0]            aspect_r;
  logic                   last_r;
  logic [15:0]            row_aspects_r [jrl_pkg::MAX_ROW_ITEMS];
  logic [FILL_W-1:0]      fill_r;
  logic [SUM_W-1:0]       sum_r;
  logic [Q24_W-1:0]       cursor_r;
  logic [IDX_W-1:0]       counter_r;

  // Working registers.
  logic [MR_W-1:0]        mul_r;
  logic [NAT_W-1:0]       nat_r;
  logic [MA_W-1:0]        prod_r;
  logic [15:0]            avail_r;
  logic                   keep_r;
  logic                   final_r;
  logic [SUM_W-1:0]       rem_r;
  logic [jrl_pkg::DIV_N-1:0] quo_r;
  logic [jrl_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [Q24_W-1:0]       h_r;
  logic [Q24_W-1:0]       x_r;
  logic [IDX_W-1:0]       base_r;
  logic [K_W-1:0]         k_r;
  jrl_pkg::tile_t         pend_r;
  logic                   pend_v_r;
  jrl_pkg::tile_t         out_r;
  logic                   out_v_r;

  // Zero becomes 1.0, everything else is clamped to 0.125 .. 8.
  function automatic logic [15:0] sanitize(input logic [15:0] a);
    logic [15:0] s;
    if (a == 16'd0) begin
      s = jrl_pkg::ASPECT_ONE;
    end else if (a < jrl_pkg::ASPECT_MIN) begin
      s = jrl_pkg::ASPECT_MIN;
    end else if (a > jrl_pkg::ASPECT_MAX) begin
      s = jrl_pkg::ASPECT_MAX;
    end else begin
      s = a;
    end
    return s;
  endfunction

  // Gap terms, in pixels and in Q8.4.
  logic [GT_W-1:0]  gap_n1, gap_n2;
  logic [11:0]      gap16;
  assign gap_n1 = GT_W'(gap_r) * (GT_W'(fill_r) + GT_W'(1));
  assign gap_n2 = GT_W'(gap_r) * (GT_W'(fill_r) + GT_W'(2));
  assign gap16  = {gap_r, 4'b0};

  // Fit decision on the natural widths with and without the new item.
  logic [NAT_W-1:0] prev_c;
  logic [NAT_W:0]   pair_c, vp2_c;
  logic [NAT_W-1:0] vp_c;
  assign vp_c   = NAT_W'({vw_r, 12'b0});
  assign prev_c = NAT_W'(mul_r[MA_W-1:0]) + NAT_W'({gap_n1, 12'b0});
  assign pair_c = (NAT_W + 1)'(nat_r) + (NAT_W + 1)'(prev_c);
  assign vp2_c  = {vp_c, 1'b0};

  // Available width after the gaps, never below the floor.
  logic [16:0] gap_px_c;
  logic [15:0] avail_c;
  assign gap_px_c = 17'(gap_n1);
  assign avail_c  = (17'(vw_r) < gap_px_c + 17'(jrl_pkg::AVAIL_MIN)) ?
                    jrl_pkg::AVAIL_MIN : 16'(17'(vw_r) - gap_px_c);

  // Stretch limits, both exact.
  logic keep_c;
  assign keep_c = (MR_W'({avail_r, 24'b0}) > mul_r) ||
                  (final_r && (MA_W'({avail_r, 12'b0}) > prod_r));

  // One restoring division step.
  logic [SUM_W:0]   trial_c;
  logic             take_c;
  assign trial_c = {rem_r, quo_r[jrl_pkg::DIV_N-1]};
  assign take_c  = (trial_c >= {1'b0, sum_r});

  // Shared multiplier.
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MR_W-1:0] mul_res;
  always_comb begin
    mul_a = MA_W'(sum_r);
    mul_b = MB_W'(rh_r);
    unique case (cmd.op)
      jrl_pkg::OP_MUL_NEXT: mul_a = MA_W'(sum_r) + MA_W'(aspect_r);
      jrl_pkg::OP_F_MUL2: begin
        mul_a = mul_r[MA_W-1:0];
        mul_b = ms_r;
      end
      jrl_pkg::OP_T_MUL: begin
        mul_a = MA_W'(h_r);
        mul_b = row_aspects_r[k_r];
      end
      default: begin
        mul_a = MA_W'(sum_r);
        mul_b = MB_W'(rh_r);
      end
    endcase
  end
  assign mul_res = MR_W'(mul_a) * MR_W'(mul_b);

  // Tile being formed and the saturated next x.
  logic [27:0]      w_raw;
  logic [Q24_W-1:0] w_sat;
  logic [25:0]      x_sum;
  logic [Q24_W-1:0] x_next;
  logic [25:0]      cy_sum;
  logic [Q24_W-1:0] cy_next;
  jrl_pkg::tile_t   new_tile;
  jrl_pkg::tile_t   fin_tile;
  assign w_raw   = mul_r[39:12];
  assign w_sat   = (|w_raw[27:24]) ? {Q24_W{1'b1}} : w_raw[Q24_W-1:0];
  assign x_sum   = 26'(x_r) + 26'(w_sat) + 26'(gap16);
  assign x_next  = (|x_sum[25:24]) ? {Q24_W{1'b1}} : x_sum[Q24_W-1:0];
  assign cy_sum  = 26'(cursor_r) + 26'(h_r) + 26'(gap16);
  assign cy_next = (|cy_sum[25:24]) ? {Q24_W{1'b1}} : cy_sum[Q24_W-1:0];

  always_comb begin
    new_tile              = '0;
    new_tile.image_index  = base_r + IDX_W'(k_r);
    new_tile.tile_x       = x_r;
    new_tile.tile_y       = cursor_r;
    new_tile.tile_width   = w_sat;
    new_tile.tile_height  = h_r;
  end

  // The last tile of an item carries the run and gallery marks.
  always_comb begin
    fin_tile                = pend_r;
    fin_tile.last_of_run    = 1'b1;
    fin_tile.layout_done    = last_r;
    fin_tile.gallery_height = last_r ? cursor_r : '0;
  end

  logic out_free;
  assign out_free = !out_v_r || out_ready;

  // The pending tile moves on to the output register.
  logic out_load;
  assign out_load = pend_v_r &&
                    ((cmd.op == jrl_pkg::OP_T_EMIT) || (cmd.op == jrl_pkg::OP_FIN));

  // Status to the controller.
  always_comb begin
    status.fill_zero  = (fill_r == '0);
    status.fill_full  = (fill_r == FILL_W'(jrl_pkg::MAX_ROW_ITEMS));
    status.nat_ge     = (nat_r >= vp_c);
    status.tie_ok     = (pair_c <= vp2_c);
    status.keep       = keep_c;
    status.div_last   = (div_cnt_r == jrl_pkg::DIV_CNT_W'(jrl_pkg::DIV_N - 1));
    status.k_last     = ((FILL_W'(k_r) + FILL_W'(1)) == fill_r);
    status.pend_valid = pend_v_r;
    status.out_free   = out_free;
    status.last_item  = last_r;
  end

  assign out_valid = out_v_r;
  assign out_tile  = out_r;

  // Configuration, row state, cursor and the tile handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r      <= jrl_pkg::VIEWPORT_RESET;
      rh_r      <= jrl_pkg::ROW_H_RESET;
      gap_r     <= jrl_pkg::GAP_RESET;
      ms_r      <= jrl_pkg::STRETCH_RESET;
      fill_r    <= '0;
      sum_r     <= '0;
      cursor_r  <= '0;
      counter_r <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jrl_pkg::CFG_VIEWPORT:
            vw_r <= (cfg_data < jrl_pkg::VIEWPORT_MIN) ? jrl_pkg::VIEWPORT_MIN : cfg_data;
          jrl_pkg::CFG_ROW_HEIGHT:
            rh_r <= (cfg_data[11:0] < jrl_pkg::ROW_H_MIN) ? jrl_pkg::ROW_H_MIN :
                    cfg_data[11:0];
          jrl_pkg::CFG_GAP:         gap_r <= cfg_data[7:0];
          jrl_pkg::CFG_MAX_STRETCH: ms_r  <= cfg_data;
          default: ;
        endcase
      end
      out_v_r <= out_load || (out_v_r && !out_ready);
      unique case (cmd.op)
        jrl_pkg::OP_PUSH: begin
          fill_r    <= fill_r + FILL_W'(1);
          sum_r     <= sum_r + SUM_W'(aspect_r);
          counter_r <= counter_r + IDX_W'(1);
        end
        jrl_pkg::OP_F_H: begin
          if (cursor_r == '0) begin
            cursor_r <= Q24_W'(gap16);
          end
        end
        jrl_pkg::OP_T_EMIT: begin
          pend_v_r <= 1'b1;
        end
        jrl_pkg::OP_F_END: begin
          cursor_r <= cy_next;
          fill_r   <= '0;
          sum_r    <= '0;
        end
        jrl_pkg::OP_FIN: begin
          pend_v_r <= 1'b0;
          if (last_r) begin
            fill_r    <= '0;
            sum_r     <= '0;
            cursor_r  <= '0;
            counter_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and tile payloads.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      jrl_pkg::OP_LOAD: begin
        aspect_r <= sanitize(in_aspect);
        last_r   <= in_last;
      end
      jrl_pkg::OP_MUL_NEXT: mul_r <= mul_res;
      jrl_pkg::OP_MUL_SUM: begin
        nat_r <= NAT_W'(mul_r[MA_W-1:0]) + NAT_W'({gap_n2, 12'b0});
        mul_r <= mul_res;
      end
      jrl_pkg::OP_PUSH: row_aspects_r[fill_r[K_W-1:0]] <= aspect_r;
      jrl_pkg::OP_F_MUL1: begin
        mul_r   <= mul_res;
        avail_r <= avail_c;
        final_r <= cmd.final_row;
      end
      jrl_pkg::OP_F_MUL2: begin
        prod_r <= mul_r[MA_W-1:0];
        mul_r  <= mul_res;
      end
      jrl_pkg::OP_F_KEEP: begin
        keep_r    <= keep_c;
        rem_r     <= '0;
        quo_r     <= {avail_r, 16'b0};
        div_cnt_r <= '0;
      end
      jrl_pkg::OP_DIV_STEP: begin
        rem_r     <= take_c ? SUM_W'(trial_c - {1'b0, sum_r}) : trial_c[SUM_W-1:0];
        quo_r     <= {quo_r[jrl_pkg::DIV_N-2:0], take_c};
        div_cnt_r <= div_cnt_r + jrl_pkg::DIV_CNT_W'(1);
      end
      jrl_pkg::OP_F_H: begin
        h_r    <= keep_r ? Q24_W'({rh_r, 4'b0}) : quo_r[Q24_W-1:0];
        x_r    <= Q24_W'(gap16);
        k_r    <= '0;
        base_r <= counter_r - IDX_W'(fill_r);
      end
      jrl_pkg::OP_T_MUL: mul_r <= mul_res;
      jrl_pkg::OP_T_EMIT: begin
        if (pend_v_r) begin
          out_r <= pend_r;
        end
        pend_r <= new_tile;
        x_r    <= x_next;
        k_r    <= k_r + K_W'(1);
      end
      jrl_pkg::OP_FIN: begin
        if (pend_v_r) begin
          out_r <= fin_tile;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/justified_row_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// justified_row_layout: justified gallery row packer
// Packs image aspect ratios greedily into rows and emits one placed tile
// per image when a row closes.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item that only joins the open row is
// loaded, checked against a full row, tested for fit and pushed; every row
// it closes adds the scale tests, the divider when the row is scaled (one
// quotient bit a cycle), a pass through the shared multiplier per tile and
// a cursor update. Each item that causes tiles ends with last_of_run on its
// final tile, and the last tile of a gallery carries layout_done and the
// total height. The configuration port is always ready.
module justified_row_layout (
  input  logic         clk,
  input  logic         rst_n,
  jrl_in_if.sink       in_if,
  jrl_out_if.source    out_if,
  jrl_cfg_if.sink      cfg_if
);

  jrl_pkg::dp_cmd_t    cmd;
  jrl_pkg::dp_status_t status;
  jrl_pkg::tile_t      tile;

  assign cfg_if.ready = 1'b1;

  // Sequencer.
  jrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath.
  jrl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .in_aspect (in_if.aspect),
    .in_last   (in_if.last_image),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_tile  (tile)
  );

  // Tile fields onto the output channel.
  assign out_if.image_index    = tile.image_index;
  assign out_if.tile_x         = tile.tile_x;
  assign out_if.tile_y         = tile.tile_y;
  assign out_if.tile_width     = tile.tile_width;
  assign out_if.tile_height    = tile.tile_height;
  assign out_if.last_of_run    = tile.last_of_run;
  assign out_if.layout_done    = tile.layout_done;
  assign out_if.gallery_height = tile.gallery_height;

endmodule

// ===== rtl/jrl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrl_checker: port checks for the justified row layout
// Watches the top level's channels and flags behaviour the block must not show.
// ----------------------------------------------------------------------------
module jrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        last_of_run,
  input logic        layout_done,
  input logic [23:0] gallery_height
);

  // A stalled tile stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("tile withdrawn while stalled");

  // The gallery's last tile is also the last of its item.
  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && layout_done |-> last_of_run)
    else $error("layout_done without last_of_run");

  // Total height is shown only with layout_done.
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !layout_done |-> gallery_height == 24'd0)
    else $error("gallery_height set on an inner tile");

  // An accepted item keeps the input closed in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened straight after an item");

endmodule

bind justified_row_layout jrl_checker u_jrl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .last_of_run    (out_if.last_of_run),
  .layout_done    (out_if.layout_done),
  .gallery_height (out_if.gallery_height)
);
